// ===== rtl/csma_cd_mac_controller_defines.svh =====
// ----------------------------------------------------------------------------
// CSMA/CD MAC controller assertion macros
// Shared macros for the concurrent checks placed at the end of the modules.
// ----------------------------------------------------------------------------
`ifndef CSMA_CD_MAC_CONTROLLER_DEFINES_SVH
`define CSMA_CD_MAC_CONTROLLER_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define CMAC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CMAC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cmac_pkg.sv =====
// ----------------------------------------------------------------------------
// CSMA/CD MAC controller package
// Item layouts, event codes, register indexes and shared constants.
// ----------------------------------------------------------------------------
package cmac_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = FIFO_AW + 1;
    localparam int MAX_EV     = 3;
    localparam int ROOM_LIMIT = FIFO_DEPTH - 2 * MAX_EV;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 16;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_REQ    = 2'd1;
    localparam logic [1:0] FUNC_ARRIVE = 2'd2;

    localparam logic [2:0] EV_TX_START = 3'd0;
    localparam logic [2:0] EV_TX_OK    = 3'd1;
    localparam logic [2:0] EV_TX_DROP  = 3'd2;
    localparam logic [2:0] EV_DELIVER  = 3'd3;
    localparam logic [2:0] EV_RX_DROP  = 3'd4;
    localparam logic [2:0] EV_COLL     = 3'd5;
    localparam logic [2:0] EV_READY    = 3'd6;
    localparam logic [2:0] EV_REFUSED  = 3'd7;

    localparam logic [CFG_AW-1:0] CFG_STATION_ADDR  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_LINK_UP       = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ATTEMPT_LIMIT = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_BACKOFF_CAP   = 2'd3;

    localparam logic [15:0] BROADCAST_DEST  = 16'hFFFF;
    localparam logic [15:0] LFSR_SEED       = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS       = 16'hB400;
    localparam logic [3:0]  BACKOFF_EXP_MAX = 4'd10;
    localparam logic [4:0]  ATTEMPT_SAT     = 5'd31;

    typedef struct packed {
        logic        frame_error;
        logic [6:0]  pad_bytes;
        logic [15:0] dest_address;
        logic [10:0] frame_bytes;
        logic [1:0]  func;
    } t_item;

    typedef struct packed {
        logic [15:0] station_address;
        logic        link_up;
        logic [4:0]  attempt_limit;
        logic [3:0]  backoff_cap;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  code;
        logic [10:0] length;
        logic        bcast;
    } t_ev;

    typedef struct packed {
        t_ev [MAX_EV-1:0] ev;
        logic [1:0]       cnt;
    } t_evlist;

    typedef struct packed {
        t_ev  ev;
        logic last;
    } t_res;

    function automatic t_evlist add_ev(t_evlist l, logic [2:0] code, logic [10:0] len,
                                       logic bc);
        t_evlist r;
        r = l;
        if (l.cnt < 2'd3) begin
            r.ev[l.cnt] = '{code: code, length: len, bcast: bc};
            r.cnt = l.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/csma_cd_mac_controller.sv =====
// ----------------------------------------------------------------------------
// CSMA/CD MAC controller
// Half-duplex MAC with carrier sense, collision jam, interframe gap and
// truncated binary exponential backoff, driven by bit-time tick items.
//
// Usage: each slave-side item is a tick, a transmit request or the start of
// an arriving frame, selected by s_axis_tuser. Every item yields zero to three
// result items on the master side; the last of them carries m_axis_tlast.
// An accepted item is registered, then handled in one pass the next cycle;
// its results are pushed into the result queue and taken from there. The controller
// accepts one item per cycle as long as the result queue has room for two
// items' worth of results; a slow receiver fills the queue and then
// s_axis_tready drops until results are taken. Reset empties the queue,
// clears all timers and the pending frame, and restores the register
// defaults (link up, 16 attempts, backoff exponent limit 10).
// Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
`include "csma_cd_mac_controller_defines.svh"

module csma_cd_mac_controller #(
    parameter int MIN_FRAME_BYTES = 64,
    parameter int HEADER_BYTES    = 14,
    parameter int SLOT_BITS       = 512,
    parameter int GAP_BITS        = 96,
    parameter int JAM_BITS        = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // frame_bytes, dest_address, pad_bytes, frame_error, zero fill
    input  logic [cmac_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [cmac_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // delivered_length, is_broadcast, zero fill
    output logic [cmac_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // event_code
    output logic [cmac_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [cmac_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [cmac_pkg::CFG_DW-1:0]     i_cfg_wdata
);
    import cmac_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    t_evlist events;
    t_res    res;
    logic    room;
    logic    in_acc;

    assign s_axis_tready = room;
    assign in_acc        = s_axis_tvalid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.station_address <= '0;
            r_cfg.link_up         <= 1'b1;
            r_cfg.attempt_limit   <= 5'd16;
            r_cfg.backoff_cap     <= 4'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_STATION_ADDR:  r_cfg.station_address <= i_cfg_wdata;
                CFG_LINK_UP:       r_cfg.link_up         <= i_cfg_wdata[0];
                CFG_ATTEMPT_LIMIT: r_cfg.attempt_limit   <= i_cfg_wdata[4:0];
                CFG_BACKOFF_CAP:   r_cfg.backoff_cap     <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.func         <= s_axis_tuser;
            r_in.frame_bytes  <= s_axis_tdata[10:0];
            r_in.dest_address <= s_axis_tdata[26:11];
            r_in.pad_bytes    <= s_axis_tdata[33:27];
            r_in.frame_error  <= s_axis_tdata[34];
        end
    end

    cmac_core #(
        .MIN_FRAME_BYTES (MIN_FRAME_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .SLOT_BITS       (SLOT_BITS),
        .GAP_BITS        (GAP_BITS),
        .JAM_BITS        (JAM_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_events (events)
    );

    cmac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (events),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (res),
        .o_room  (room)
    );

    assign m_axis_tdata = {4'b0000, res.ev.bcast, res.ev.length};
    assign m_axis_tuser = res.ev.code;
    assign m_axis_tlast = res.last;

    `CMAC_ASSERT_IMPLY(a_refuse_alone, i_clk, i_rst_n, r_in_valid && events.cnt != 2'd0 && events.ev[0].code == EV_REFUSED, events.cnt == 2'd1, "refused request produced extra results")
    `CMAC_ASSERT_IMPLY(a_bcast_only_deliver, i_clk, i_rst_n, m_axis_tvalid && res.ev.bcast, res.ev.code == EV_DELIVER, "broadcast flag on a non-delivery result")
    `CMAC_ASSERT_IMPLY(a_len_only_deliver, i_clk, i_rst_n, m_axis_tvalid && res.ev.code != EV_DELIVER, res.ev.length == '0, "length on a non-delivery result")

endmodule

// ===== rtl/cmac_fifo.sv =====
// ----------------------------------------------------------------------------
// CSMA/CD MAC result queue
// Takes up to three results per cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
`include "csma_cd_mac_controller_defines.svh"

module cmac_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cmac_pkg::t_evlist i_push,
    input  logic             i_pop,
    output logic             o_valid,
    output cmac_pkg::t_res   o_res,
    output logic             o_room
);
    import cmac_pkg::*;

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign o_room  = (r_count <= CNT_W'(ROOM_LIMIT));
    assign do_pop  = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_EV; i++) begin
            if (2'(i) < i_push.cnt) begin
                r_mem[r_wr + FIFO_AW'(i)] <= '{ev: i_push.ev[i],
                                               last: ((2'(i) + 2'd1) == i_push.cnt)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push.cnt);
            r_rd    <= r_rd + FIFO_AW'(do_pop);
            r_count <= r_count + CNT_W'(i_push.cnt) - CNT_W'(do_pop);
        end
    end

    `CMAC_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(FIFO_DEPTH), "queue count above depth")
    `CMAC_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push.cnt != 2'd0, (r_count + CNT_W'(i_push.cnt)) <= CNT_W'(FIFO_DEPTH), "queue overflow on push")

endmodule

// ===== rtl/cmac_core.sv =====
// ----------------------------------------------------------------------------
// CSMA/CD MAC protocol core
// Holds the timers, retry state and random source, and turns one registered
// item into its state update and up to three results combinationally.
// ----------------------------------------------------------------------------
`include "csma_cd_mac_controller_defines.svh"

module cmac_core #(
    parameter int MIN_FRAME_BYTES = 64,
    parameter int HEADER_BYTES    = 14,
    parameter int SLOT_BITS       = 512,
    parameter int GAP_BITS        = 96,
    parameter int JAM_BITS        = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cmac_pkg::t_item   i_item,
    input  cmac_pkg::t_cfg    i_cfg,
    output cmac_pkg::t_evlist o_events
);
    import cmac_pkg::*;

    localparam int WIRE_MAX = (2047 + HEADER_BYTES > MIN_FRAME_BYTES) ?
                              (2047 + HEADER_BYTES) : MIN_FRAME_BYTES;
    localparam int TX_W  = $clog2(8 * WIRE_MAX + 1);
    localparam int RX_W  = $clog2(8 * 2047 + 1);
    localparam int GAP_W = $clog2(JAM_BITS + GAP_BITS + 1);
    localparam int BO_W  = $clog2(1023 * SLOT_BITS + JAM_BITS + GAP_BITS + 1);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEND = 2'd1,
        MODE_RECV = 2'd2
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [TX_W-1:0]   r_tx, n_tx;
    logic [RX_W-1:0]   r_rx, n_rx;
    logic [GAP_W-1:0]  r_gap, n_gap;
    logic [BO_W-1:0]   r_bo, n_bo;
    logic [4:0]        r_att, n_att;
    logic              r_pend, n_pend;
    logic [10:0]       r_plen, n_plen;
    logic [15:0]       r_rx_dest, n_rx_dest;
    logic [10:0]       r_rx_len, n_rx_len;
    logic [6:0]        r_rx_pad, n_rx_pad;
    logic              r_rx_err, n_rx_err;
    logic [15:0]       r_lfsr, n_lfsr;
    logic              r_upw, n_upw;
    t_evlist           n_ev;

    always_comb begin
        logic            tx_f, rx_f, bo_f, gd, lsb, hit;
        logic [TX_W-1:0] wire_len;
        logic [5:0]      tries;
        logic [3:0]      cap, k;
        logic [9:0]      mask, rnd;
        logic [7:0]      strip;

        n_mode    = r_mode;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_gap     = r_gap;
        n_bo      = r_bo;
        n_att     = r_att;
        n_pend    = r_pend;
        n_plen    = r_plen;
        n_rx_dest = r_rx_dest;
        n_rx_len  = r_rx_len;
        n_rx_pad  = r_rx_pad;
        n_rx_err  = r_rx_err;
        n_lfsr    = r_lfsr;
        n_upw     = r_upw;
        n_ev      = '0;
        tx_f      = 1'b0;
        rx_f      = 1'b0;
        bo_f      = 1'b0;
        gd        = 1'b0;
        lsb       = 1'b0;
        hit       = 1'b0;
        wire_len  = TX_W'(r_plen) + TX_W'(HEADER_BYTES);
        tries     = '0;
        cap       = '0;
        k         = '0;
        mask      = '0;
        rnd       = '0;
        strip     = 8'(HEADER_BYTES) + {1'b0, r_rx_pad};

        if (i_valid) begin
            unique case (i_item.func)
                FUNC_TICK: begin
                    if (n_tx != '0) begin
                        n_tx = n_tx - TX_W'(1);
                        tx_f = (n_tx == '0);
                    end
                    if (n_rx != '0) begin
                        n_rx = n_rx - RX_W'(1);
                        rx_f = (n_rx == '0);
                    end
                    if (n_bo != '0) begin
                        n_bo = n_bo - BO_W'(1);
                        bo_f = (n_bo == '0);
                    end
                    if (n_gap != '0) begin
                        n_gap = n_gap - GAP_W'(1);
                        gd    = (n_gap == '0);
                    end
                    if (tx_f) begin
                        n_pend = 1'b0;
                        n_att  = '0;
                        n_bo   = '0;
                        n_gap  = GAP_W'(GAP_BITS);
                        n_ev   = add_ev(n_ev, EV_TX_OK, '0, 1'b0);
                    end
                    if (rx_f) begin
                        hit = ((r_rx_dest == BROADCAST_DEST) ||
                               (r_rx_dest == i_cfg.station_address)) && !r_rx_err;
                        if (hit) begin
                            n_ev = add_ev(n_ev, EV_DELIVER,
                                          (r_rx_len > {3'b000, strip}) ?
                                          (r_rx_len - {3'b000, strip}) : 11'd0,
                                          r_rx_dest == BROADCAST_DEST);
                        end else begin
                            n_ev = add_ev(n_ev, EV_RX_DROP, '0, 1'b0);
                        end
                        n_gap = GAP_W'(GAP_BITS);
                    end
                    if (bo_f && n_pend) begin
                        if (n_att < ATTEMPT_SAT) begin
                            n_att = n_att + 5'd1;
                        end
                        if (!i_cfg.link_up) begin
                            n_pend = 1'b0;
                            n_att  = '0;
                            n_bo   = '0;
                        end else if (n_gap == '0 && !gd && n_mode == MODE_IDLE) begin
                            if (wire_len < TX_W'(MIN_FRAME_BYTES)) begin
                                wire_len = TX_W'(MIN_FRAME_BYTES);
                            end
                            n_tx   = wire_len << 3;
                            n_mode = MODE_SEND;
                            n_ev   = add_ev(n_ev, EV_TX_START, '0, 1'b0);
                        end
                    end
                    if (gd) begin
                        n_mode = MODE_IDLE;
                        if (n_pend) begin
                            if (n_bo == '0) begin
                                if (!i_cfg.link_up) begin
                                    n_pend = 1'b0;
                                    n_att  = '0;
                                    n_bo   = '0;
                                end else if (n_gap == '0) begin
                                    if (wire_len < TX_W'(MIN_FRAME_BYTES)) begin
                                        wire_len = TX_W'(MIN_FRAME_BYTES);
                                    end
                                    n_tx   = wire_len << 3;
                                    n_mode = MODE_SEND;
                                    n_ev   = add_ev(n_ev, EV_TX_START, '0, 1'b0);
                                end
                            end
                        end else if (n_upw && n_bo == '0) begin
                            n_upw = 1'b0;
                            n_ev  = add_ev(n_ev, EV_READY, '0, 1'b0);
                        end
                    end
                end
                FUNC_REQ: begin
                    if (!i_cfg.link_up || r_pend) begin
                        n_ev = add_ev(n_ev, EV_REFUSED, '0, 1'b0);
                    end else begin
                        n_pend   = 1'b1;
                        n_plen   = i_item.frame_bytes;
                        n_att    = '0;
                        n_upw    = 1'b1;
                        wire_len = TX_W'(i_item.frame_bytes) + TX_W'(HEADER_BYTES);
                        if (r_gap == '0 && r_mode == MODE_IDLE) begin
                            if (wire_len < TX_W'(MIN_FRAME_BYTES)) begin
                                wire_len = TX_W'(MIN_FRAME_BYTES);
                            end
                            n_tx   = wire_len << 3;
                            n_mode = MODE_SEND;
                            n_ev   = add_ev(n_ev, EV_TX_START, '0, 1'b0);
                        end
                    end
                end
                FUNC_ARRIVE: begin
                    if (!i_cfg.link_up || (r_mode != MODE_IDLE && r_gap != '0)) begin
                        n_ev = add_ev(n_ev, EV_RX_DROP, '0, 1'b0);
                    end else if (r_mode == MODE_IDLE) begin
                        n_mode    = MODE_RECV;
                        n_rx_dest = i_item.dest_address;
                        n_rx_len  = i_item.frame_bytes;
                        n_rx_pad  = i_item.pad_bytes;
                        n_rx_err  = i_item.frame_error;
                        n_rx      = (i_item.frame_bytes != '0) ?
                                    RX_W'({i_item.frame_bytes, 3'b000}) : RX_W'(1);
                    end else begin
                        n_gap = GAP_W'(JAM_BITS + GAP_BITS);
                        n_ev  = add_ev(n_ev, EV_COLL, '0, 1'b0);
                        if (r_mode == MODE_SEND) begin
                            n_tx = '0;
                            if (r_pend && r_bo == '0) begin
                                tries = {1'b0, r_att} + 6'd1;
                                if (tries < {1'b0, i_cfg.attempt_limit}) begin
                                    cap = (i_cfg.backoff_cap < BACKOFF_EXP_MAX) ?
                                          i_cfg.backoff_cap : BACKOFF_EXP_MAX;
                                    k   = (tries < {2'b00, cap}) ? tries[3:0] : cap;
                                    lsb    = r_lfsr[0];
                                    n_lfsr = r_lfsr >> 1;
                                    if (lsb) begin
                                        n_lfsr = n_lfsr ^ LFSR_TAPS;
                                    end
                                    mask = ~(10'h3FF << k);
                                    rnd  = n_lfsr[9:0] & mask;
                                    n_bo = BO_W'(rnd) * BO_W'(SLOT_BITS) +
                                           BO_W'(JAM_BITS + GAP_BITS);
                                end else begin
                                    n_pend = 1'b0;
                                    n_att  = '0;
                                    n_bo   = '0;
                                    n_ev   = add_ev(n_ev, EV_TX_DROP, '0, 1'b0);
                                end
                            end
                        end else begin
                            n_rx = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_events = n_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_tx      <= '0;
            r_rx      <= '0;
            r_gap     <= '0;
            r_bo      <= '0;
            r_att     <= '0;
            r_pend    <= 1'b0;
            r_plen    <= '0;
            r_rx_dest <= '0;
            r_rx_len  <= '0;
            r_rx_pad  <= '0;
            r_rx_err  <= 1'b0;
            r_lfsr    <= LFSR_SEED;
            r_upw     <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_gap     <= n_gap;
            r_bo      <= n_bo;
            r_att     <= n_att;
            r_pend    <= n_pend;
            r_plen    <= n_plen;
            r_rx_dest <= n_rx_dest;
            r_rx_len  <= n_rx_len;
            r_rx_pad  <= n_rx_pad;
            r_rx_err  <= n_rx_err;
            r_lfsr    <= n_lfsr;
            r_upw     <= n_upw;
        end
    end

    `CMAC_ASSERT_IMPLY(a_backoff_needs_frame, i_clk, i_rst_n, !r_pend, r_bo == '0,
                       "backoff running without a pending frame")
    `CMAC_ASSERT_IMPLY(a_attempts_need_frame, i_clk, i_rst_n, r_att != '0, r_pend,
                       "attempt count kept after frame was released")
    `CMAC_ASSERT_ALWAYS(a_lfsr_nonzero, i_clk, i_rst_n, r_lfsr != '0,
                        "random source locked at zero")

endmodule
